@@ hdl/command_frame_encoder_assert.svh @@
// Assertion macros used by the command frame encoder checker.
`ifndef COMMAND_FRAME_ENCODER_ASSERT_SVH
`define COMMAND_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfe check failed");

// Next-cycle implication, disabled while in reset.
`define CFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfe check failed");

`endif

@@ hdl/cfe_pkg.sv @@
// Types and constants shared by the command frame encoder modules.
`timescale 1ns / 1ps
`default_nettype none
package cfe_pkg;

	localparam logic [7:0] SYNC_A = 8'hEB;
	localparam logic [7:0] SYNC_B = 8'h90;

	// Input op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Byte index inside one job, 0..8
	localparam int IDX_W = 4;

	typedef enum logic [1:0] {
		JOB_HDR   = 2'd0,
		JOB_DATA  = 2'd1,
		JOB_STRAY = 2'd2
	} job_kind_t;

	// One classified item, handed from front to back
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] flen;
		logic [7:0]  rcv;
		logic [7:0]  own;
		logic [7:0]  cmd1;
		logic [7:0]  cmd2;
		logic        two;
		logic        close;   // checksum follows
		logic [7:0]  csum;
		logic [7:0]  data;
	} job_t;

endpackage
`default_nettype wire

@@ hdl/cfe_front.sv @@
// Front end: accepts items, tracks frame state and classifies into jobs.
`timescale 1ns / 1ps
`default_nettype none
module cfe_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_wdata,
	input  wire logic         accept,
	input  wire logic         op,
	input  wire logic [15:0]  payload_length,
	input  wire logic [7:0]   receive_code,
	input  wire logic [7:0]   command_code,
	input  wire logic [7:0]   second_command_code,
	input  wire logic         two_codes,
	input  wire logic [7:0]   data_byte,
	output cfe_pkg::job_t     job
);

	logic [7:0]  own_q;
	logic [15:0] rem_q;
	logic [7:0]  sum_q;
	logic        open_q;

	logic [15:0] flen;
	logic [7:0]  hsum;
	logic [7:0]  dsum;
	logic [15:0] drem;
	logic [15:0] rem_d;
	logic [7:0]  sum_d;
	logic        open_d;

	// Header length and partial checksum
	always_comb begin
		flen = payload_length + (two_codes ? 16'd7 : 16'd6);
		hsum = flen[7:0] + flen[15:8] + receive_code + own_q + command_code
			+ (two_codes ? second_command_code : 8'd0);
		dsum = sum_q + data_byte;
		drem = rem_q - 16'd1;
	end

	// Classify the item and compute next frame state
	always_comb begin
		job       = '0;
		job.flen  = flen;
		job.rcv   = receive_code;
		job.own   = own_q;
		job.cmd1  = command_code;
		job.cmd2  = second_command_code;
		job.two   = two_codes;
		job.data  = data_byte;
		rem_d     = rem_q;
		sum_d     = sum_q;
		open_d    = open_q;
		if (op == cfe_pkg::OP_START) begin
			job.kind  = cfe_pkg::JOB_HDR;
			job.close = (payload_length == 16'd0);
			job.csum  = 8'd0 - hsum;
			open_d    = (payload_length != 16'd0);
			rem_d     = payload_length;
			sum_d     = (payload_length == 16'd0) ? 8'd0 : hsum;
		end else if (!open_q) begin
			job.kind  = cfe_pkg::JOB_STRAY;
		end else begin
			job.kind  = cfe_pkg::JOB_DATA;
			job.close = (drem == 16'd0);
			job.csum  = 8'd0 - dsum;
			open_d    = (drem != 16'd0);
			rem_d     = drem;
			sum_d     = (drem == 16'd0) ? 8'd0 : dsum;
		end
	end

	// Frame state and own address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= '0;
			rem_q  <= '0;
			sum_q  <= '0;
			open_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (accept) begin
				rem_q  <= rem_d;
				sum_q  <= sum_d;
				open_q <= open_d;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/cfe_queue.sv @@
// Small job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module cfe_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  cfe_pkg::job_t      push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output cfe_pkg::job_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfe_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/cfe_back.sv @@
// Back end: expands queued jobs into frame bytes, one per cycle unless out_ready stalls.
`timescale 1ns / 1ps
`default_nettype none
module cfe_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	input  cfe_pkg::job_t    job,
	output logic             job_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_of_run,
	output logic             end_of_frame,
	output logic             stray_error
);

	logic [cfe_pkg::IDX_W-1:0] idx_q;
	logic [cfe_pkg::IDX_W-1:0] last_idx;
	logic                      advance;
	logic                      at_last;
	logic [7:0]                byte_d;
	logic                      err_d;

	logic                      valid_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      eof_q;
	logic                      err_q;

	assign advance = job_valid && (!valid_q || out_ready);
	assign at_last = (idx_q == last_idx);
	assign job_pop = advance && at_last;

	// Byte selection for the current index
	always_comb begin
		byte_d   = 8'd0;
		err_d    = 1'b0;
		last_idx = '0;
		case (job.kind)
			cfe_pkg::JOB_HDR: begin
				last_idx = cfe_pkg::IDX_W'(6) + cfe_pkg::IDX_W'(job.two)
					+ cfe_pkg::IDX_W'(job.close);
				case (idx_q)
					4'd0:    byte_d = cfe_pkg::SYNC_A;
					4'd1:    byte_d = cfe_pkg::SYNC_B;
					4'd2:    byte_d = job.flen[7:0];
					4'd3:    byte_d = job.flen[15:8];
					4'd4:    byte_d = job.rcv;
					4'd5:    byte_d = job.own;
					4'd6:    byte_d = job.cmd1;
					4'd7:    byte_d = job.two ? job.cmd2 : job.csum;
					default: byte_d = job.csum;
				endcase
			end
			cfe_pkg::JOB_DATA: begin
				last_idx = cfe_pkg::IDX_W'(job.close);
				byte_d   = (idx_q == '0) ? job.data : job.csum;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	// Job index counter and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= at_last ? '0 : idx_q + cfe_pkg::IDX_W'(1);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= byte_d;
			last_q <= at_last;
			eof_q  <= at_last && job.close;
			err_q  <= err_d;
		end
	end

	assign out_valid    = valid_q;
	assign frame_byte   = byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;
	assign stray_error  = err_q;

endmodule
`default_nettype wire

@@ hdl/command_frame_encoder.sv @@
// Command frame encoder: top level tying front end, job queue and back end.
//
// A start item produces the frame header (sync bytes, length, receiver, own
// address, one or two command codes) and, for an empty payload, the checksum:
// 7 to 9 output transfers. Each payload item produces one transfer, or two
// for the last byte of a frame (byte, then checksum marked end_of_frame). A
// payload byte with no open frame gives one transfer with stray_error set.
// Unless out_ready stalls it, the back end emits one byte per cycle, so payload
// items that do not close a frame stream at one per cycle, while the front end
// keeps accepting into a QUEUE_DEPTH-entry job queue. The user must write
// own_address via cfg_we/cfg_wdata only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module command_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  receive_code,
	input  wire logic [7:0]  command_code,
	input  wire logic [7:0]  second_command_code,
	input  wire logic        two_codes,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_of_run,
	output logic             end_of_frame,
	output logic             stray_error
);

	cfe_pkg::job_t new_job;
	cfe_pkg::job_t head_job;
	logic          q_full;
	logic          q_not_empty;
	logic          q_pop;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	cfe_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.accept              (accept),
		.op                  (op),
		.payload_length      (payload_length),
		.receive_code        (receive_code),
		.command_code        (command_code),
		.second_command_code (second_command_code),
		.two_codes           (two_codes),
		.data_byte           (data_byte),
		.job                 (new_job)
	);

	cfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_job  (new_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	cfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_not_empty),
		.job          (head_job),
		.job_pop      (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.stray_error  (stray_error)
	);

endmodule
`default_nettype wire

@@ hdl/cfe_checker.sv @@
// Port-level checker for the command frame encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_encoder_assert.svh"
module cfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] frame_byte,
	input wire logic       last_of_run,
	input wire logic       end_of_frame,
	input wire logic       stray_error
);

	// A stalled result holds
	`CFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(last_of_run))
	// The checksum always closes its item's run
	`CFE_ASSERT_IMPLY(a_eof_last, clk, arst_n, out_valid && end_of_frame, last_of_run && !stray_error)
	// A stray result is a lone zero byte
	`CFE_ASSERT_IMPLY(a_stray_form, clk, arst_n, out_valid && stray_error, last_of_run && frame_byte == 8'd0 && !end_of_frame)
	// A result that does not end its run is a plain frame byte
	`CFE_ASSERT_IMPLY(a_mid_plain, clk, arst_n, out_valid && !last_of_run, !stray_error && !end_of_frame)

endmodule

bind command_frame_encoder cfe_checker u_cfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_byte   (frame_byte),
	.last_of_run  (last_of_run),
	.end_of_frame (end_of_frame),
	.stray_error  (stray_error)
);
`default_nettype wire

@@ verif/command_frame_encoder_tb.sv @@
// Self-checking testbench for the command frame encoder: header, payload and checksum bytes.
`timescale 1ns / 1ps
module command_frame_encoder_tb;

	localparam int LIMIT_CYCLES = 500000;

	// one command as presented on the input channel
	typedef struct {
		logic        op;
		logic [15:0] plen;
		logic [7:0]  rcv;
		logic [7:0]  cmd1;
		logic [7:0]  cmd2;
		logic        two;
		logic [7:0]  data;
	} cmd_item_t;

	// one byte as it should leave the output channel
	typedef struct {
		logic [7:0] frame_b;
		logic       is_last;
		logic       is_eof;
		logic       is_stray;
	} frame_out_t;

	// Frame model and byte checker
	class frame_checker;
		logic [7:0]  own_addr = 8'h00;
		logic [15:0] bytes_left = 16'h0000;
		logic [7:0]  byte_sum = 8'h00;
		bit          frame_active = 1'b0;
		frame_out_t  expected_bytes[$];
		int          mismatches = 0;
		int          bytes_checked = 0;
		int          frames_closed = 0;
		int          strays = 0;
		int          commands = 0;

		function void set_own(logic [7:0] v);
			own_addr = v;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		task report_mismatch(string what, int got, int want);
			mismatches++;
			// keep the log short if the block is badly broken
			if (mismatches <= 60)
				$display("MISMATCH at byte %0d: %s got %0h want %0h", bytes_checked, what,
					got, want);
		endtask

		function void push_byte(logic [7:0] b, bit lst, bit eof, bit err);
			frame_out_t r;
			r.frame_b = b;
			r.is_last = lst;
			r.is_eof = eof;
			r.is_stray = err;
			expected_bytes.push_back(r);
		endfunction

		// works out every byte that one accepted command causes
		function void note_command(cmd_item_t c);
			logic [7:0]  hdr[8];
			logic [15:0] flen;
			int          nh;
			commands++;
			if (c.op == cfe_pkg::OP_DATA) begin
				if (!frame_active) begin
					strays++;
					push_byte(8'h00, 1'b1, 1'b0, 1'b1);
					return;
				end
				byte_sum = byte_sum + c.data;
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'd0) begin
					push_byte(c.data, 1'b0, 1'b0, 1'b0);
					push_byte(8'(8'h00 - byte_sum), 1'b1, 1'b1, 1'b0);
					frames_closed++;
					frame_active = 0;
					byte_sum = 8'h00;
				end else begin
					push_byte(c.data, 1'b1, 1'b0, 1'b0);
				end
				return;
			end
			// start: header, any open frame is dropped without checksum
			flen = c.plen + (c.two ? 16'd7 : 16'd6);
			hdr[0] = cfe_pkg::SYNC_A;
			hdr[1] = cfe_pkg::SYNC_B;
			hdr[2] = flen[7:0];
			hdr[3] = flen[15:8];
			hdr[4] = c.rcv;
			hdr[5] = own_addr;
			hdr[6] = c.cmd1;
			hdr[7] = c.cmd2;
			nh = c.two ? 8 : 7;
			byte_sum = 8'h00;
			for (int i = 2; i < nh; i++)
				byte_sum = byte_sum + hdr[i];
			for (int i = 0; i < nh; i++)
				push_byte(hdr[i], (i == nh - 1) && (c.plen != 16'd0), 1'b0, 1'b0);
			if (c.plen == 16'd0) begin
				push_byte(8'(8'h00 - byte_sum), 1'b1, 1'b1, 1'b0);
				frames_closed++;
				frame_active = 0;
				bytes_left = 16'd0;
				byte_sum = 8'h00;
			end else begin
				frame_active = 1;
				bytes_left = c.plen;
			end
		endfunction

		// compares one output transfer with the oldest expected byte
		task check_byte(frame_out_t got);
			frame_out_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected output, frame_byte", got.frame_b, 0);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.frame_b !== want.frame_b)
				report_mismatch("frame_byte", got.frame_b, want.frame_b);
			if (got.is_last !== want.is_last)
				report_mismatch("last_of_run", got.is_last, want.is_last);
			if (got.is_eof !== want.is_eof)
				report_mismatch("end_of_frame", got.is_eof, want.is_eof);
			if (got.is_stray !== want.is_stray)
				report_mismatch("stray_error", got.is_stray, want.is_stray);
			bytes_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [15:0] payload_length;
	logic [7:0]  receive_code;
	logic [7:0]  command_code;
	logic [7:0]  second_command_code;
	logic        two_codes;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  frame_byte;
	logic        last_of_run;
	logic        end_of_frame;
	logic        stray_error;

	frame_checker sb = new();
	bit           idle_on = 1'b1;
	int           addr_settings = 0;
	int           cycles = 0;

	command_frame_encoder i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.op                 (op),
		.payload_length     (payload_length),
		.receive_code       (receive_code),
		.command_code       (command_code),
		.second_command_code(second_command_code),
		.two_codes          (two_codes),
		.data_byte          (data_byte),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.frame_byte         (frame_byte),
		.last_of_run        (last_of_run),
		.end_of_frame       (end_of_frame),
		.stray_error        (stray_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d bytes outstanding", cycles, sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Monitor: note input transfers first, then check output transfers
	always @(posedge clk) begin
		cmd_item_t  c;
		frame_out_t r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				c.op = op;
				c.plen = payload_length;
				c.rcv = receive_code;
				c.cmd1 = command_code;
				c.cmd2 = second_command_code;
				c.two = two_codes;
				c.data = data_byte;
				sb.note_command(c);
			end
			if (out_valid && out_ready) begin
				r.frame_b = frame_byte;
				r.is_last = last_of_run;
				r.is_eof = end_of_frame;
				r.is_stray = stray_error;
				sb.check_byte(r);
			end
		end
	end

	// Output backpressure in random bursts
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// presents one command and holds it until the transfer
	task drive_item(cmd_item_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c.op;
		payload_length <= c.plen;
		receive_code <= c.rcv;
		command_code <= c.cmd1;
		second_command_code <= c.cmd2;
		two_codes <= c.two;
		data_byte <= c.data;
		do @(posedge clk); while (!in_ready);
	endtask

	task send_start(logic [15:0] plen, logic [7:0] rcv, logic [7:0] c1, logic [7:0] c2,
		logic two);
		cmd_item_t c;
		c.op = cfe_pkg::OP_START;
		c.plen = plen;
		c.rcv = rcv;
		c.cmd1 = c1;
		c.cmd2 = c2;
		c.two = two;
		c.data = 8'($urandom);
		drive_item(c);
	endtask

	// payload byte; header fields carry junk that must be ignored
	task send_data(logic [7:0] d);
		cmd_item_t c;
		c.op = cfe_pkg::OP_DATA;
		c.plen = 16'($urandom);
		c.rcv = 8'($urandom);
		c.cmd1 = 8'($urandom);
		c.cmd2 = 8'($urandom);
		c.two = 1'($urandom);
		c.data = d;
		drive_item(c);
	endtask

	// waits for every expected byte, then lets the pipeline settle
	task wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task write_own_address(logic [7:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		sb.set_own(v);
		addr_settings++;
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed frames with random content, some strays and abandoned frames
	task run_frames(int n_items);
		int sent;
		int pick;
		int plen;
		int nsend;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_data(8'($urandom));
				sent++;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					plen = $urandom_range(0, 6);
				else if (pick < 92)
					plen = $urandom_range(7, 24);
				else
					plen = $urandom_range(0, 65535);
				send_start(16'(plen), 8'($urandom), 8'($urandom), 8'($urandom),
					1'($urandom));
				sent++;
				nsend = plen;
				// long frames and a few short ones are cut off by the next start
				if (plen > 24)
					nsend = $urandom_range(0, 4);
				else if (plen > 0 && $urandom_range(0, 9) == 0)
					nsend = $urandom_range(0, plen - 1);
				for (int i = 0; i < nsend; i++) begin
					send_data(8'($urandom));
					sent++;
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// Main sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'h00;
		in_valid <= 1'b0;
		op <= cfe_pkg::OP_START;
		payload_length <= 16'h0000;
		receive_code <= 8'h00;
		command_code <= 8'h00;
		second_command_code <= 8'h00;
		two_codes <= 1'b0;
		data_byte <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, empty frames, last byte, abandon, length wrap, strays
		write_own_address(8'hFF);
		send_data(8'hFF);
		send_start(16'h0000, 8'hFF, 8'hFF, 8'h00, 1'b0);
		send_start(16'h0000, 8'h00, 8'h00, 8'hFF, 1'b1);
		send_start(16'h0001, 8'h5A, 8'hA5, 8'h3C, 1'b1);
		send_data(8'h00);
		send_start(16'h0003, 8'h01, 8'h80, 8'h7F, 1'b0);
		send_data(8'hFF);
		send_data(8'h55);
		send_data(8'hAA);
		send_start(16'h0002, 8'h10, 8'h20, 8'h30, 1'b0);
		send_data(8'h12);
		send_start(16'hFFFF, 8'hC3, 8'h3C, 8'hE7, 1'b1);
		send_data(8'h7E);
		send_data(8'h81);
		send_start(16'd65529, 8'h44, 8'h99, 8'h11, 1'b0);
		send_data(8'h01);
		send_start(16'd65528, 8'hAB, 8'hCD, 8'hEF, 1'b1);
		send_start(16'h0001, 8'h02, 8'h04, 8'h08, 1'b0);
		send_data(8'hFF);
		send_data(8'h33);
		in_valid <= 1'b0;
		wait_drained();

		write_own_address(8'h00);
		run_frames(90);
		wait_drained();
		write_own_address(8'($urandom));
		run_frames(90);
		wait_drained();
		write_own_address(8'h80);
		run_frames(80);
		wait_drained();

		// last part runs at full rate on both sides
		idle_on = 1'b0;
		write_own_address(8'($urandom));
		run_frames(75);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Ran %0d commands under %0d address settings: %0d frames closed, %0d strays",
			sb.commands, addr_settings, sb.frames_closed, sb.strays);
		$display("Checked %0d output bytes, %0d mismatches", sb.bytes_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
